[src/wgs_pkg.sv]
// ----------------------------------------------------------------------------
// wgs_pkg: shared codes and widths for the wave grid stencil step unit
// Opcodes and register indexes.
// ----------------------------------------------------------------------------
package wgs_pkg;
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_DISTURB = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP = 2'd2;
    localparam logic [OP_W-1:0] OP_READ = 2'd3;
    localparam int CFG_W = 15;
    localparam logic CFG_COEFF = 1'b0;
    localparam logic CFG_DIP = 1'b1;
    localparam int CW = 6;
endpackage

[src/wave_grid_stencil_step_unit.sv]
// ----------------------------------------------------------------------------
// wave_grid_stencil_step_unit: 2-D five-point wave equation on a height grid
// Three rotating buffers in one synchronous memory; read-modify-write control.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, cell_row, cell_col,
//   load_height. Output channel (out_valid/out_ready) returns one word per
//   input word: height and saturated.
//   One word is processed at a time; in_ready is high only while idle.
//   A load writes the word once into each buffer; a read or disturb does a
//   memory read, and a disturb then writes its result back; a step sweeps
//   all interior cells.
//   For each interior cell a step does six reads through the one
//   read port (four neighbors, center, previous), waits for the last read
//   data, then does one multiply-add and one write.
//   The next word is taken in the cycle after a result enters
//   the output register.
//   While the receiver stalls, one result waits in the output register and
//   the next word is processed; that word then holds in its done state with
//   in_ready low until the output register is taken.
//   Reset clears control, the buffer index and the output valid flag and sets
//   the registers (coeff 1638, dip 64). Memory is undefined until loaded.
module wave_grid_stencil_step_unit #(
    parameter int GRID_SIZE = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [wgs_pkg::CFG_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic [wgs_pkg::OP_W-1:0] opcode,
    input  logic [wgs_pkg::CW-1:0] cell_row,
    input  logic [wgs_pkg::CW-1:0] cell_col,
    input  logic signed [15:0] load_height,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [15:0] height,
    output logic saturated
);
    import wgs_pkg::*;

    localparam int GB = $clog2(GRID_SIZE);
    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int AW = $clog2(3 * CELLS);
    localparam int HW = HEIGHT_BITS;
    localparam logic signed [HW+1:0] HMAX = (HW+2)'((64'sd1 <<< (HW-1)) - 1);
    localparam logic signed [HW+1:0] HMIN = -HMAX - 1;
    localparam int AB = HW + 22;   // accumulator width

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LOAD   = 9'b000000010,
        S_RD     = 9'b000000100,
        S_RDW    = 9'b000001000,
        S_FIN    = 9'b000010000,
        S_SRD    = 9'b000100000,
        S_SMUL   = 9'b001000000,
        S_SWR    = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] cur_reg;
    logic [CFG_W-1:0] coeff_reg, dip_reg;
    logic [OP_W-1:0] op_reg;
    logic [GB-1:0] row_reg, col_reg;
    logic signed [HW-1:0] lh_reg;
    logic [1:0] cnt_reg;        // load buffer counter
    logic [2:0] tap_reg;        // stencil read index
    logic [2:0] tap_d_reg;      // tap of data arriving this cycle
    logic tap_v_reg;
    logic signed [HW+1:0] sum_reg;
    logic signed [HW-1:0] ctr_reg, prv_reg;
    logic signed [AB-1:0] acc_reg;
    logic signed [15:0] h_reg;
    logic sat_reg;

    // output register
    logic out_v_reg;
    logic signed [15:0] out_h_reg;
    logic out_s_reg;
    logic out_load;

    logic signed [HW-1:0] mem [0:3*CELLS-1];
    logic signed [HW-1:0] rdata;
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic signed [HW-1:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    function automatic logic [AW-1:0] addr_of(input logic [1:0] b, input logic [GB-1:0] r,
                                              input logic [GB-1:0] c);
        addr_of = AW'(b) * AW'(CELLS) + AW'(r) * AW'(GRID_SIZE) + AW'(c);
    endfunction

    logic [1:0] prev_b, next_b;
    assign prev_b = (cur_reg == 2'd0) ? 2'd2 : cur_reg - 2'd1;
    assign next_b = (cur_reg == 2'd2) ? 2'd0 : cur_reg + 2'd1;

    logic in_grid;
    assign in_grid = (32'(cell_row) < GRID_SIZE) && (32'(cell_col) < GRID_SIZE);

    // stencil read address for current tap
    always_comb
    begin
        case (tap_reg)
            3'd0: raddr = addr_of(cur_reg, row_reg + GB'(1), col_reg);
            3'd1: raddr = addr_of(cur_reg, row_reg - GB'(1), col_reg);
            3'd2: raddr = addr_of(cur_reg, row_reg, col_reg + GB'(1));
            3'd3: raddr = addr_of(cur_reg, row_reg, col_reg - GB'(1));
            3'd4: raddr = addr_of(cur_reg, row_reg, col_reg);
            default: raddr = addr_of(prev_b, row_reg, col_reg);
        endcase
        if (state_reg != S_SRD)
        begin
            raddr = addr_of(cur_reg, row_reg, col_reg);
        end
    end

    // disturbance
    logic signed [HW+1:0] dis;
    assign dis = (HW+2)'(rdata) - (HW+2)'($signed({1'b0, dip_reg}));

    // rounding and clamp of the accumulator
    logic signed [AB-1:0] rnd;
    logic sclip;
    logic signed [HW-1:0] sval;
    assign rnd = (acc_reg + AB'(8192)) >>> 14;
    always_comb
    begin
        sclip = 1'b0;
        sval = HW'(rnd);
        if (rnd > AB'(HMAX))
        begin
            sclip = 1'b1;
            sval = HW'(HMAX);
        end
        else if (rnd < AB'(HMIN))
        begin
            sclip = 1'b1;
            sval = HW'(HMIN);
        end
    end

    logic signed [HW-1:0] lh_sat;
    always_comb
    begin
        if (HW >= 16)
        begin
            lh_sat = HW'(load_height);
        end
        else if ((HW+18)'(load_height) > (HW+18)'(HMAX))
        begin
            lh_sat = HW'(HMAX);
        end
        else if ((HW+18)'(load_height) < (HW+18)'(HMIN))
        begin
            lh_sat = HW'(HMIN);
        end
        else
        begin
            lh_sat = HW'(load_height);
        end
    end

    logic last_tap;
    assign last_tap = tap_v_reg && (tap_d_reg == 3'd5);

    // result moves to the output register once that register is free
    assign out_load = (state_reg == S_DONE) && (!out_v_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        waddr = addr_of(cur_reg, row_reg, col_reg);
        wdata = lh_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_STEP)
                    begin
                        state_next = S_SRD;
                    end
                    else if (!in_grid)
                    begin
                        state_next = S_DONE;
                    end
                    else if (opcode == OP_LOAD)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_LOAD:
            begin
                we = 1'b1;
                waddr = addr_of(cnt_reg, row_reg, col_reg);
                if (cnt_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
            end
            S_RD: state_next = S_RDW;
            S_RDW:
            begin
                if (op_reg == OP_DISTURB)
                begin
                    we = 1'b1;
                    wdata = (dis < HMIN) ? HW'(HMIN) : HW'(dis);
                end
                state_next = S_DONE;
            end
            S_SRD:
            begin
                if (last_tap)
                begin
                    state_next = S_SMUL;
                end
            end
            S_SMUL: state_next = S_SWR;
            S_SWR:
            begin
                we = 1'b1;
                waddr = addr_of(next_b, row_reg, col_reg);
                wdata = sval;
                if ((32'(row_reg) == GRID_SIZE - 2) && (32'(col_reg) == GRID_SIZE - 2))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SRD;
                end
            end
            S_FIN: state_next = S_DONE;
            S_DONE:
            begin
                if (!out_v_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg <= 2'd0;
            coeff_reg <= CFG_W'(1638);
            dip_reg <= CFG_W'(64);
            tap_reg <= 3'd0;
            tap_d_reg <= 3'd0;
            tap_v_reg <= 1'b0;
            cnt_reg <= 2'd0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_COEFF)
                begin
                    coeff_reg <= cfg_data;
                end
                else
                begin
                    dip_reg <= cfg_data;
                end
            end
            cnt_reg <= (state_reg == S_LOAD) ? cnt_reg + 2'd1 : 2'd0;
            tap_v_reg <= (state_reg == S_SRD) && (tap_reg <= 3'd5);
            tap_d_reg <= tap_reg;
            if (state_reg == S_SRD)
            begin
                if (tap_reg <= 3'd5)
                begin
                    tap_reg <= tap_reg + 3'd1;
                end
            end
            else
            begin
                tap_reg <= 3'd0;
            end
            if (state_reg == S_FIN)
            begin
                cur_reg <= next_b;
            end
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg <= opcode;
            row_reg <= (opcode == OP_STEP) ? GB'(1) : GB'(cell_row);
            col_reg <= (opcode == OP_STEP) ? GB'(1) : GB'(cell_col);
            lh_reg <= lh_sat;
            h_reg <= 16'sd0;
            sat_reg <= 1'b0;
        end
        if (state_reg == S_LOAD)
        begin
            h_reg <= 16'(lh_reg);
        end
        if (state_reg == S_RDW)
        begin
            if (op_reg == OP_DISTURB)
            begin
                h_reg <= 16'((dis < HMIN) ? HW'(HMIN) : HW'(dis));
                sat_reg <= dis < HMIN;
            end
            else
            begin
                h_reg <= 16'(rdata);
            end
        end
        if (tap_v_reg)
        begin
            case (tap_d_reg)
                3'd0: sum_reg <= (HW+2)'(rdata);
                3'd1, 3'd2, 3'd3: sum_reg <= sum_reg + (HW+2)'(rdata);
                3'd4: ctr_reg <= rdata;
                default: prv_reg <= rdata;
            endcase
        end
        if (state_reg == S_SMUL)
        begin
            acc_reg <= AB'($signed({1'b0, coeff_reg})) * AB'(sum_reg)
                     + (AB'(32768) - (AB'($signed({1'b0, coeff_reg})) <<< 2)) * AB'(ctr_reg)
                     - (AB'(prv_reg) <<< 14);
        end
        if (state_reg == S_SWR)
        begin
            if (sclip)
            begin
                sat_reg <= 1'b1;
            end
            if (32'(col_reg) == GRID_SIZE - 2)
            begin
                col_reg <= GB'(1);
                row_reg <= row_reg + GB'(1);
            end
            else
            begin
                col_reg <= col_reg + GB'(1);
            end
        end
        if (out_load)
        begin
            out_h_reg <= h_reg;
            out_s_reg <= sat_reg;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_v_reg;
    assign height = out_h_reg;
    assign saturated = out_s_reg;

`ifndef SYNTHESIS
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid && !out_ready |=> state_reg == S_DONE)
        else $error("result left done state while output full");
    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg != 2'd3) else $error("buffer index out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(height))
        else $error("result changed while stalled");
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |=> state_reg == S_DONE) else $error("step did not finish");
`endif
endmodule
